/* hw/rtl/lsb_stego_payload_extractor_macros.svh */
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Shared concurrent assertion forms for the extractor checkers.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define LSEP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/lsep_pkg.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Result kinds, error codes, register indexes and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsep_pkg;

   localparam int PixelW  = 8;
   localparam int ValueW  = 32;
   localparam int MagicW  = 64;
   localparam int MlenW   = 4;
   localparam int KindW   = 2;
   localparam int ErrW    = 2;
   localparam int CsrAddrW = 1;
   localparam int RspDataW = 40;

   typedef enum logic [KindW-1:0] {
      KIND_EXT     = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_SIZE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [ErrW-1:0] {
      ERR_MAGIC     = 2'd0,
      ERR_EXT_LEN   = 2'd1,
      ERR_ZERO_SIZE = 2'd2,
      ERR_TRUNCATED = 2'd3
   } err_type;

   typedef enum logic [CsrAddrW-1:0] {
      REG_MAGIC_PATTERN = 1'd0,
      REG_MAGIC_LENGTH  = 1'd1
   } reg_index_type;

endpackage

/* hw/rtl/lsb_stego_payload_extractor.sv */
// The result of an accepted beat, if any, is registered in the output register.
// Throughput: one beat per cycle; req_tready drops only while a result is
// held unconsumed, the output register being the only stage.
// Reset: synchronous, active high; clears the parser to header skip, loads
// the register defaults (magic 0x2A23, length 2) and empties the output.
// ----------------------------------------------------------------------------
// LSB stego payload extractor
// Skips the image header, gathers pixel LSBs into bytes and lengths, checks
// the magic and streams out extension bytes, payload size and payload bytes, or an error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_stego_payload_extractor #(
   parameter int HEADER_BYTES  = 54,
   parameter int MAX_EXTENSION = 9
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req: tdata = pixel_byte[7:0]; tuser = image_start; tlast = image_end
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [lsep_pkg::PixelW-1:0]            req_tdata,
   input  logic                                   req_tuser,
   input  logic                                   req_tlast,
   // rsp: tdata = value[31:0], error_code[33:32], zero pad; tuser = kind
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [lsep_pkg::RspDataW-1:0]          rsp_tdata,
   output logic [lsep_pkg::KindW-1:0]             rsp_tuser,
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [lsep_pkg::CsrAddrW-1:0]          csr_addr,
   input  logic [lsep_pkg::MagicW-1:0]            csr_wdata
);

   localparam int HdrW = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXTLEN,
      PH_EXT,
      PH_SIZE,
      PH_PAYLOAD,
      PH_IDLE
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [HdrW-1:0]               hdr_cnt_ff, hdr_cnt_in;
   logic [lsep_pkg::ValueW-1:0]   shift_ff, shift_in;
   logic [4:0]                    bit_cnt_ff, bit_cnt_in;
   logic                          mismatch_ff, mismatch_in;
   logic [3:0]                    field_cnt_ff, field_cnt_in;
   logic [lsep_pkg::ValueW-1:0]   remain_ff, remain_in;
   logic [lsep_pkg::MagicW-1:0]   magic_ff, magic_in;
   logic [lsep_pkg::MlenW-1:0]    mlen_ff, mlen_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   lsep_pkg::kind_type            rsp_kind_ff, rsp_kind_in;
   logic [lsep_pkg::ValueW-1:0]   rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;
   lsep_pkg::err_type             rsp_err_ff, rsp_err_in;

   logic                          accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(lsep_pkg::RspDataW - lsep_pkg::ValueW - lsep_pkg::ErrW){1'b0}},
                        rsp_err_ff, rsp_value_ff};

   always_comb begin
      logic                        have;
      lsep_pkg::kind_type          kind;
      lsep_pkg::err_type           err;
      logic [lsep_pkg::ValueW-1:0] val;
      logic                        last;
      logic [lsep_pkg::ValueW-1:0] word;
      logic                        wide;
      logic                        done;
      logic [3:0]                  len;
      logic [3:0]                  fc_inc;
      logic [lsep_pkg::ValueW-1:0] rem_dec;

      magic_in = magic_ff;
      mlen_in  = mlen_ff;
      if (csr_we) begin
         case (csr_addr)
            lsep_pkg::REG_MAGIC_PATTERN: magic_in = csr_wdata;
            lsep_pkg::REG_MAGIC_LENGTH:  mlen_in  = csr_wdata[lsep_pkg::MlenW-1:0];
            default: ;
         endcase
      end

      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      shift_in     = shift_ff;
      bit_cnt_in   = bit_cnt_ff;
      mismatch_in  = mismatch_ff;
      field_cnt_in = field_cnt_ff;
      remain_in    = remain_ff;

      have = 1'b0;
      kind = lsep_pkg::KIND_EXT;
      err  = lsep_pkg::ERR_MAGIC;
      val  = '0;
      last = 1'b0;

      if (req_tuser) begin
         phase_in     = PH_HEADER;
         hdr_cnt_in   = '0;
         shift_in     = '0;
         bit_cnt_in   = '0;
         mismatch_in  = 1'b0;
         field_cnt_in = '0;
         remain_in    = '0;
      end

      len = mlen_ff;
      if (len == 4'd0) len = 4'd1;
      if (len > 4'd8)  len = 4'd8;
      fc_inc  = field_cnt_in + 4'd1;
      rem_dec = remain_in - 32'd1;

      word = shift_in | (32'(req_tdata[0]) << bit_cnt_in);
      wide = (phase_in == PH_EXTLEN) || (phase_in == PH_SIZE);
      done = wide ? (bit_cnt_in == 5'd31) : (bit_cnt_in == 5'd7);

      if (phase_in != PH_IDLE) begin
         if (phase_in == PH_HEADER && hdr_cnt_in < HdrW'(HEADER_BYTES)) begin
            hdr_cnt_in = hdr_cnt_in + HdrW'(1);
         end else if (!done) begin
            if (phase_in == PH_HEADER) phase_in = PH_MAGIC;
            shift_in   = word;
            bit_cnt_in = bit_cnt_in + 5'd1;
         end else begin
            shift_in   = '0;
            bit_cnt_in = '0;
            case (phase_in)
               PH_HEADER, PH_MAGIC: begin
                  // header skip with one-bit fields never ends a field here
                  phase_in = PH_MAGIC;
                  if (word[7:0] != magic_ff[8*field_cnt_in[2:0] +: 8]) mismatch_in = 1'b1;
                  field_cnt_in = fc_inc;
                  if (fc_inc >= len) begin
                     if (mismatch_in) begin
                        have = 1'b1; kind = lsep_pkg::KIND_ERROR;
                        err  = lsep_pkg::ERR_MAGIC;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_EXTLEN;
                     end
                  end
               end
               PH_EXTLEN: begin
                  if (word == '0 || word > 32'(MAX_EXTENSION)) begin
                     have = 1'b1; kind = lsep_pkg::KIND_ERROR;
                     err  = lsep_pkg::ERR_EXT_LEN;
                     phase_in = PH_IDLE;
                  end else begin
                     remain_in = word;
                     phase_in  = PH_EXT;
                  end
               end
               PH_EXT: begin
                  have = 1'b1; kind = lsep_pkg::KIND_EXT; val = {24'd0, word[7:0]};
                  remain_in = rem_dec;
                  if (rem_dec == '0) phase_in = PH_SIZE;
               end
               PH_SIZE: begin
                  have = 1'b1;
                  if (word == '0) begin
                     kind = lsep_pkg::KIND_ERROR; err = lsep_pkg::ERR_ZERO_SIZE;
                     phase_in = PH_IDLE;
                  end else begin
                     kind = lsep_pkg::KIND_SIZE; val = word;
                     remain_in = word;
                     phase_in  = PH_PAYLOAD;
                  end
               end
               default: begin
                  have = 1'b1; kind = lsep_pkg::KIND_PAYLOAD; val = {24'd0, word[7:0]};
                  remain_in = rem_dec;
                  if (rem_dec == '0) begin
                     last     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end

         if (req_tlast && phase_in != PH_IDLE) begin
            have = 1'b1; kind = lsep_pkg::KIND_ERROR; err = lsep_pkg::ERR_TRUNCATED;
            phase_in = PH_IDLE;
         end
      end

      if (kind == lsep_pkg::KIND_ERROR) begin
         val  = '0;
         last = 1'b0;
      end else begin
         err = lsep_pkg::ERR_MAGIC;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (accept) begin
         rsp_valid_in = have;
         rsp_kind_in  = kind;
         rsp_value_in = val;
         rsp_last_in  = last;
         rsp_err_in   = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= '0;
         shift_ff     <= '0;
         bit_cnt_ff   <= '0;
         mismatch_ff  <= 1'b0;
         field_cnt_ff <= '0;
         remain_ff    <= '0;
         magic_ff     <= 64'd10787;
         mlen_ff      <= 4'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            shift_ff     <= shift_in;
            bit_cnt_ff   <= bit_cnt_in;
            mismatch_ff  <= mismatch_in;
            field_cnt_ff <= field_cnt_in;
            remain_ff    <= remain_in;
         end
         magic_ff     <= magic_in;
         mlen_ff      <= mlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

/* hw/rtl/lsep_checker.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lsb_stego_payload_extractor_macros.svh"

module lsep_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lsep_pkg::RspDataW-1:0]      rsp_tdata,
   input logic [lsep_pkg::KindW-1:0]         rsp_tuser,
   input logic                               rsp_tlast
);

   `LSEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp beat changed while stalled")

   `LSEP_ASSERT_NOW(a_err_clean, clock, reset, rsp_tvalid && rsp_tuser == lsep_pkg::KIND_ERROR, rsp_tdata[31:0] == 32'd0 && !rsp_tlast, "error beat carries data or last")

   `LSEP_ASSERT_NOW(a_last_payload, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == lsep_pkg::KIND_PAYLOAD, "last flag on non-payload beat")

   `LSEP_ASSERT_NOW(a_byte_range, clock, reset, rsp_tvalid && (rsp_tuser == lsep_pkg::KIND_EXT || rsp_tuser == lsep_pkg::KIND_PAYLOAD), rsp_tdata[31:8] == 24'd0 && rsp_tdata[33:32] == 2'd0, "byte beat out of range")

   `LSEP_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "input stalled with empty output")

endmodule

bind lsb_stego_payload_extractor lsep_checker u_lsep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
